// ===== rtl/core/vme_pkg.sv =====
package vme_pkg;

    localparam int STRESS_WIDTH_DEF = 24;
    localparam int OUT_WIDTH        = 26;

    typedef enum logic [1:0] {
        FUNC_PLANE_STRESS = 2'd0,
        FUNC_PLANE_STRAIN = 2'd1,
        FUNC_FULL_3D      = 2'd2,
        FUNC_UNSUPPORTED  = 2'd3
    } t_func;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_ctl;

endpackage

// ===== rtl/core/vme_front.sv =====
module vme_front #(
    parameter int STRESS_WIDTH = vme_pkg::STRESS_WIDTH_DEF,
    parameter int QW           = 2 * STRESS_WIDTH + 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  vme_pkg::t_func            i_func,
    input  logic [STRESS_WIDTH-1:0]   i_c1,
    input  logic [STRESS_WIDTH-1:0]   i_c2,
    input  logic [STRESS_WIDTH-1:0]   i_c3,
    input  logic [STRESS_WIDTH-1:0]   i_c4,
    input  logic [STRESS_WIDTH-1:0]   i_c5,
    input  logic [STRESS_WIDTH-1:0]   i_c6,
    output vme_pkg::t_ctl             o_ctl,
    output logic [QW-1:0]             o_q
);
    import vme_pkg::*;

    localparam int W  = STRESS_WIDTH;
    localparam int MW = W + 1;

    function automatic logic [MW-1:0] mag(input logic [MW-1:0] x);
        mag = x[MW-1] ? (~x + MW'(1)) : x;
    endfunction

    logic signed [MW-1:0] w_e1, w_e2, w_e3, w_e4, w_e5, w_e6;
    logic signed [MW-1:0] w_d12, w_d23, w_d31;
    logic [MW-1:0] n_x1, n_x2, n_x3, n_y1, n_y2, n_y3;
    logic [MW-1:0] r_x1, r_x2, r_x3, r_y1, r_y2, r_y3;
    logic [QW-1:0] r_sx1, r_sx2, r_sx3, r_sy1, r_sy2, r_sy3;
    logic [QW-1:0] r_q;
    t_ctl          r_ctl1, r_ctl2, r_ctl3;
    logic          n_ok;
    logic [QW:0]   w_nsum, w_ssum;
    logic [QW+2:0] w_total;

    assign w_e1 = $signed({i_c1[W-1], i_c1});
    assign w_e2 = $signed({i_c2[W-1], i_c2});
    assign w_e3 = $signed({i_c3[W-1], i_c3});
    assign w_e4 = $signed({i_c4[W-1], i_c4});
    assign w_e5 = $signed({i_c5[W-1], i_c5});
    assign w_e6 = $signed({i_c6[W-1], i_c6});
    assign w_d12 = w_e1 - w_e2;
    assign w_d23 = w_e2 - w_e3;
    assign w_d31 = w_e3 - w_e1;

    always_comb begin
        n_ok = 1'b1;
        n_x1 = mag(w_d12);
        n_x2 = mag(w_d23);
        n_x3 = mag(w_d31);
        n_y1 = mag(w_e4);
        n_y2 = '0;
        n_y3 = '0;
        unique case (i_func)
            FUNC_PLANE_STRESS: begin
                n_x2 = mag(w_e1);
                n_x3 = mag(w_e2);
                n_y1 = mag(w_e3);
            end
            FUNC_PLANE_STRAIN: begin
            end
            FUNC_FULL_3D: begin
                n_y2 = mag(w_e5);
                n_y3 = mag(w_e6);
            end
            FUNC_UNSUPPORTED: begin
                n_ok = 1'b0;
                n_x1 = '0;
                n_x2 = '0;
                n_x3 = '0;
                n_y1 = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // normal part is halved, shear part tripled; bound keeps q below 2^QW
    assign w_nsum  = (QW+1)'(r_sx1) + (QW+1)'(r_sx2) + (QW+1)'(r_sx3);
    assign w_ssum  = (QW+1)'(r_sy1) + (QW+1)'(r_sy2) + (QW+1)'(r_sy3);
    assign w_total = (QW+3)'(w_nsum[QW:1]) + {1'b0, w_ssum, 1'b0} + (QW+3)'(w_ssum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1 <= '{valid: i_valid, ok: n_ok};
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1  <= n_x1;
            r_x2  <= n_x2;
            r_x3  <= n_x3;
            r_y1  <= n_y1;
            r_y2  <= n_y2;
            r_y3  <= n_y3;
            r_sx1 <= QW'(r_x1) * QW'(r_x1);
            r_sx2 <= QW'(r_x2) * QW'(r_x2);
            r_sx3 <= QW'(r_x3) * QW'(r_x3);
            r_sy1 <= QW'(r_y1) * QW'(r_y1);
            r_sy2 <= QW'(r_y2) * QW'(r_y2);
            r_sy3 <= QW'(r_y3) * QW'(r_y3);
            r_q   <= w_total[QW-1:0];
        end
    end

    assign o_ctl = r_ctl3;
    assign o_q   = r_q;

endmodule

// ===== rtl/core/vme_sqrt_cell.sv =====
module vme_sqrt_cell #(
    parameter int QW = 2 * vme_pkg::STRESS_WIDTH_DEF + 2,
    parameter int RW = QW / 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  vme_pkg::t_ctl   i_ctl,
    input  logic [QW-1:0]   i_q,
    input  logic [RW:0]     i_rem,
    input  logic [RW-1:0]   i_root,
    output vme_pkg::t_ctl   o_ctl,
    output logic [QW-1:0]   o_q,
    output logic [RW:0]     o_rem,
    output logic [RW-1:0]   o_root
);
    import vme_pkg::*;

    t_ctl          r_ctl;
    logic [QW-1:0] r_q;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [RW+2:0] w_acc;
    logic [RW+2:0] w_trial;
    logic          w_take;

    // one restoring step: bring in two bits of q, try (root<<2)|1
    assign w_acc   = {i_rem, i_q[QW-1:QW-2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_take  = (w_acc >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= {i_q[QW-3:0], 2'b00};
            r_rem  <= w_take ? (RW+1)'(w_acc - w_trial) : (RW+1)'(w_acc);
            r_root <= {i_root[RW-2:0], w_take};
        end
    end

    assign o_ctl  = r_ctl;
    assign o_q    = r_q;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== rtl/core/von_mises_equivalent_stress.sv =====
// Throughput: one request per cycle when the chain is not stalled; three front stages
// (select, square, sum), then one square-root cell per result bit, then the output register.
// The whole chain advances when the output register is empty or being taken.
// Reset (synchronous, active low) clears all stage valid bits; payload is not reset.
module von_mises_equivalent_stress #(
    parameter int STRESS_WIDTH = vme_pkg::STRESS_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // stress_c1, stress_c2, ..., stress_c6, zero fill
    input  logic [((6*STRESS_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    // func
    input  logic [1:0]                             i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // equivalent_stress, zero fill
    output logic [((vme_pkg::OUT_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // size_supported
    output logic                                   o_m_axis_tuser
);
    import vme_pkg::*;

    localparam int W   = STRESS_WIDTH;
    localparam int QW  = 2 * W + 2;
    localparam int RW  = QW / 2;
    localparam int ODW = ((OUT_WIDTH + 7) / 8) * 8;

    logic             w_en;
    t_ctl             w_ctl [0:RW];
    logic [QW-1:0]    w_q   [0:RW];
    logic [RW:0]      w_rem [0:RW];
    logic [RW-1:0]    w_root[0:RW];
    logic [OUT_WIDTH-1:0] n_out;
    logic [OUT_WIDTH-1:0] r_out;
    logic             r_out_valid;
    logic             r_out_ok;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    vme_front #(
        .STRESS_WIDTH(W),
        .QW          (QW)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(i_s_axis_tvalid),
        .i_func (t_func'(i_s_axis_tuser)),
        .i_c1   (i_s_axis_tdata[0*W +: W]),
        .i_c2   (i_s_axis_tdata[1*W +: W]),
        .i_c3   (i_s_axis_tdata[2*W +: W]),
        .i_c4   (i_s_axis_tdata[3*W +: W]),
        .i_c5   (i_s_axis_tdata[4*W +: W]),
        .i_c6   (i_s_axis_tdata[5*W +: W]),
        .o_ctl  (w_ctl[0]),
        .o_q    (w_q[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < RW; g++) begin : g_cell
        vme_sqrt_cell #(
            .QW(QW),
            .RW(RW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctl  (w_ctl[g]),
            .i_q    (w_q[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_ctl  (w_ctl[g+1]),
            .o_q    (w_q[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );
    end

    if (RW > OUT_WIDTH) begin : g_sat
        assign n_out = (|w_root[RW][RW-1:OUT_WIDTH]) ? '1 : w_root[RW][OUT_WIDTH-1:0];
    end else begin : g_ext
        assign n_out = OUT_WIDTH'(w_root[RW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctl[RW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out    <= w_ctl[RW].ok ? n_out : '0;
            r_out_ok <= w_ctl[RW].ok;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ODW'(r_out);
    assign o_m_axis_tuser  = r_out_ok;

    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (r_out == '0))
        else $error("unsupported request gave nonzero result");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[RW].valid |-> (w_rem[RW] <= {w_root[RW], 1'b0}))
        else $error("square root remainder out of bound");

    a_unsup_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[0].valid && !w_ctl[0].ok) |-> (w_q[0] == '0))
        else $error("unsupported request gave nonzero sum");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_ctl[RW]) && $stable(w_root[RW]))
        else $error("chain moved during stall");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vme_pkg::*;

    localparam int SW     = STRESS_WIDTH_DEF;
    localparam int DATA_W = ((6*SW+7)/8)*8;
    localparam int RES_W  = ((OUT_WIDTH+7)/8)*8;
    localparam int S_MAX  = 8388607;
    localparam int S_MIN  = -8388608;
    localparam logic [63:0] EQ_CAP = 64'd67108863;
    localparam int N_RANDOM = 1450;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] eq;
        logic                 ok;
    } t_vm_expect;

    typedef struct packed {
        t_func              func;
        logic [5:0][SW-1:0] comp;
        logic               known;
        logic [OUT_WIDTH-1:0] eq;
        logic               ok;
    } t_stress_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    // stress_c1, stress_c2, ..., stress_c6
    logic [DATA_W-1:0] i_s_axis_tdata = '0;
    // func
    logic [1:0]        i_s_axis_tuser = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // equivalent_stress, zero fill
    logic [RES_W-1:0]  o_m_axis_tdata;
    // size_supported
    logic              o_m_axis_tuser;

    t_vm_expect  expected_vm_q[$];
    t_stress_row stress_rows[$];
    int          fail_count = 0;
    int          sink_stall = 0;
    logic        bursty = 1'b0;
    t_vm_expect  want;

    von_mises_equivalent_stress u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] sq_mag(longint d);
        logic [63:0] a;
        a = (d < 0) ? 64'(-d) : 64'(d);
        return a * a;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_vm_expect von_mises_of(t_func f, logic [DATA_W-1:0] d);
        longint      s [6];
        logic [63:0] q;
        logic [63:0] r;
        t_vm_expect  e;
        for (int k = 0; k < 6; k++) s[k] = longint'($signed(d[k*SW +: SW]));
        q = 0;
        case (f)
            FUNC_PLANE_STRESS: begin
                q = ((sq_mag(s[0] - s[1]) + sq_mag(s[0]) + sq_mag(s[1])) >> 1)
                    + 64'd3 * sq_mag(s[2]);
            end
            FUNC_PLANE_STRAIN, FUNC_FULL_3D: begin
                q = ((sq_mag(s[0] - s[1]) + sq_mag(s[1] - s[2]) + sq_mag(s[2] - s[0])) >> 1)
                    + 64'd3 * sq_mag(s[3]);
                if (f == FUNC_FULL_3D) q = q + 64'd3 * (sq_mag(s[4]) + sq_mag(s[5]));
            end
            default: ;
        endcase
        e.ok = (f != FUNC_UNSUPPORTED);
        r = e.ok ? floor_sqrt(q) : 64'd0;
        if (r > EQ_CAP) r = EQ_CAP;
        e.eq = r[OUT_WIDTH-1:0];
        return e;
    endfunction

    function automatic t_stress_row mk_row(t_func f, int a1, int a2, int a3, int a4,
                                           int a5, int a6, logic known, int eq, logic ok);
        t_stress_row r;
        r.func    = f;
        r.comp[0] = a1[SW-1:0];
        r.comp[1] = a2[SW-1:0];
        r.comp[2] = a3[SW-1:0];
        r.comp[3] = a4[SW-1:0];
        r.comp[4] = a5[SW-1:0];
        r.comp[5] = a6[SW-1:0];
        r.known   = known;
        r.eq      = eq[OUT_WIDTH-1:0];
        r.ok      = ok;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(int zero_pct);
        int r;
        if (bursty) return 0;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 0;
        if (r < zero_pct + (100 - zero_pct) * 3 / 4) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SW-1:0] rand_comp(int style, int base);
        int pick;
        case (style)
            0: return SW'($urandom);
            1: return SW'($urandom_range(0, 400) - 200);
            2: begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return SW'(S_MAX);
                    1: return SW'(S_MIN);
                    2: return '0;
                    3: return '1;
                    default: return SW'(1);
                endcase
            end
            default: return SW'(base + $urandom_range(0, 64) - 32);
        endcase
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    task automatic offer_stress(t_func f, logic [DATA_W-1:0] d, logic known, t_vm_expect typed);
        int gap;
        gap = pick_gap(55);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tuser  <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_vm_q.push_back(known ? typed : von_mises_of(f, d));
    endtask

    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            i_m_axis_tready <= 1'b0;
            sink_stall--;
        end else begin
            sink_stall = pick_gap(80);
            if (sink_stall != 0) begin
                i_m_axis_tready <= 1'b0;
                sink_stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_vm_q.size() == 0) begin
                note_failure($sformatf("unexpected result: eq=%0d ok=%0b",
                                       o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                want = expected_vm_q.pop_front();
                if (o_m_axis_tdata !== RES_W'(want.eq) || o_m_axis_tuser !== want.ok)
                    note_failure($sformatf("mismatch: expected eq=%0d ok=%0b, got eq=%0d ok=%0b",
                                           want.eq, want.ok, o_m_axis_tdata, o_m_axis_tuser));
            end
        end
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_stress_row      row;
        t_func            f;
        logic [DATA_W-1:0] d;
        int               style;
        int               base;

        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, S_MAX, 0, 0, 0, 0, 0, 1'b1, S_MAX, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, S_MIN, 0, 0, 0, 0, 0,
                                     1'b1, 8388608, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, 0, S_MIN, 0, 0, 0, 0,
                                     1'b1, 8388608, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, -1, -1, 0, 0, 0, 0, 1'b1, 1, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, S_MAX, S_MIN, 0, 0, 0, 0, 1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, 0, 0, S_MIN, 0, 0, 0, 1'b0, 0, 1'b0));
        // unused c4..c6 at the other extreme
        stress_rows.push_back(mk_row(FUNC_PLANE_STRESS, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                                     1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRAIN, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRAIN, S_MAX, 0, 0, 0, 0, 0, 1'b1, S_MAX, 1'b1));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRAIN, S_MIN, S_MAX, S_MIN, S_MIN, 0, 0,
                                     1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_PLANE_STRAIN, 0, 0, 0, S_MAX, S_MIN, S_MIN,
                                     1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_FULL_3D, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
        stress_rows.push_back(mk_row(FUNC_FULL_3D, S_MIN, 0, 0, 0, 0, 0, 1'b1, 8388608, 1'b1));
        // pure hydrostatic state
        stress_rows.push_back(mk_row(FUNC_FULL_3D, 12345, 12345, 12345, 0, 0, 0, 1'b1, 0, 1'b1));
        stress_rows.push_back(mk_row(FUNC_FULL_3D, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MIN,
                                     1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_FULL_3D, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                     1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_FULL_3D, -1, -1, -1, -1, -1, -1, 1'b0, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_UNSUPPORTED, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                     1'b1, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_UNSUPPORTED, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                                     1'b1, 0, 1'b0));
        stress_rows.push_back(mk_row(FUNC_UNSUPPORTED, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stress_rows[i]) begin
            row = stress_rows[i];
            offer_stress(row.func, DATA_W'(row.comp), row.known, {row.eq, row.ok});
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            bursty = (n % 150) >= 120;
            f = ($urandom_range(0, 9) == 0) ? FUNC_UNSUPPORTED : t_func'($urandom_range(0, 2));
            style = $urandom_range(0, 9);
            style = (style < 5) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
            base  = $urandom_range(0, 32'hFFFFFF) - 8388608;
            for (int k = 0; k < 6; k++)
                d[k*SW +: SW] = rand_comp((style == 3 && k >= 3) ? 1 : style, base);
            offer_stress(f, d, 1'b0, '0);
        end
        bursty = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        while (expected_vm_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vme_pkg.sv
rtl/core/vme_front.sv
rtl/core/vme_sqrt_cell.sv
rtl/core/von_mises_equivalent_stress.sv
test/tb_top.sv
